FILE: rtl/vec3_fixed_point_alu_assert.svh
// Assertion macros for the vec3 fixed-point vector unit checker.
// Included by the checker module; depends on nothing else.
`ifndef VEC3_FIXED_POINT_ALU_ASSERT_SVH
`define VEC3_FIXED_POINT_ALU_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define VFA_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("vec3_fixed_point_alu: assertion failed");

// Clocked assertion that is also checked while reset is held.
`define VFA_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("vec3_fixed_point_alu: assertion failed during reset");

`endif

FILE: rtl/vfa_pkg.sv
// Shared types, constants and helper functions for the vec3 fixed-point unit.
// No dependencies; used by the top level and its checker.
`default_nettype none

package vfa_pkg;

    // Number format: signed fixed point, Q16.16.
    localparam int unsigned WIDTH     = 32;
    localparam int unsigned FRAC_BITS = 16;

    // Full-precision product and the widest exact sum of three products.
    localparam int unsigned PROD_W = 2 * WIDTH;
    localparam int unsigned SUM_W  = 2 * WIDTH + 2;

    // Stream payload widths.
    localparam int unsigned OP_W      = 3;
    localparam int unsigned S_TDATA_W = ((9 * WIDTH + 7) / 8) * 8;
    localparam int unsigned M_TDATA_W = ((4 * WIDTH + 7) / 8) * 8;

    // Cyclic neighbors of a vector component, used for cross products.
    localparam int unsigned NXT1 [3] = '{1, 2, 0};
    localparam int unsigned NXT2 [3] = '{2, 0, 1};

    // Operation codes carried in the request tuser.
    typedef enum logic [OP_W-1:0] {
        OP_ADD     = 3'd0,
        OP_SUB     = 3'd1,
        OP_NEG     = 3'd2,
        OP_CMUL    = 3'd3,
        OP_DOT     = 3'd4,
        OP_CROSS   = 3'd5,
        OP_STRIPLE = 3'd6,
        OP_VTRIPLE = 3'd7
    } t_op;

    typedef logic signed [WIDTH-1:0]  t_comp;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [SUM_W-1:0]  t_wide;

    typedef struct packed {
        logic  sat;
        t_comp val;
    } t_clamp;

    // Clamp a wide signed value to the WIDTH-bit signed range.
    function automatic t_clamp sat_clamp(input t_wide v);
        t_clamp r;
        logic [SUM_W-WIDTH:0] hi;
        hi = v[SUM_W-1:WIDTH-1];
        if ((&hi) || !(|hi)) begin
            r.sat = 1'b0;
            r.val = v[WIDTH-1:0];
        end else begin
            r.sat = 1'b1;
            r.val = v[SUM_W-1] ? {1'b1, {(WIDTH-1){1'b0}}} : {1'b0, {(WIDTH-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/vec3_fixed_point_alu.sv
// Three-component vector unit in signed Q16.16 fixed point, four pipeline stages.
// Depends on vfa_pkg.
//
// Usage:
//   Requests enter on the slave channel (i_s_tvalid / o_s_tready). tuser holds
//   the operation code; tdata holds A, B and C, x/y/z each, A x in the low bits.
//   Every request gives exactly one result on the master channel; tdata holds
//   res_x, res_y, res_z and res_scalar, and tuser holds the saturation flag.
//   o_m_tvalid rises once the request has passed stages one to four and its
//   result sits in the output register.
//   Throughput is one request per cycle unless the receiver stalls: stage one
//   forms the first nine products, stage two sums, truncates and clamps them,
//   stage three forms the nine products of the triple-product second pass,
//   stage four sums, clamps and selects into the output register.
//   Each stage carries a valid bit and moves on when the stage after it is
//   empty or moving, so bubbles close up. When the receiver holds i_m_tready
//   low the result stays in the output register and earlier stages keep
//   filling; o_s_tready falls only once all four stages hold requests.
//   Reset (i_rst_n low, synchronous) empties every stage; no result is lost or
//   repeated across a stall.
`default_nettype none

module vec3_fixed_point_alu
    import vfa_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Request channel.
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (low bits first)
    input  wire logic [S_TDATA_W-1:0] i_s_tdata,
    // req_type
    input  wire logic [OP_W-1:0]      i_s_tuser,
    // Result channel.
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    // res_x, res_y, res_z, res_scalar (low bits first)
    output logic [M_TDATA_W-1:0]      o_m_tdata,
    // saturated
    output logic [0:0]                o_m_tuser
);

    // Stage enables: a stage loads when it is empty or its successor loads.
    logic en1, en2, en3, en4;
    logic r_v1, r_v2, r_v3, r_v4;

    assign en4        = !r_v4 || i_m_tready;
    assign en3        = !r_v3 || en4;
    assign en2        = !r_v2 || en3;
    assign en1        = !r_v1 || en2;
    assign o_s_tready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_s_tvalid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // Unpack the request operands.
    t_comp in_a [3];
    t_comp in_b [3];
    t_comp in_c [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            in_a[i] = i_s_tdata[i*WIDTH +: WIDTH];
            in_b[i] = i_s_tdata[(3+i)*WIDTH +: WIDTH];
            in_c[i] = i_s_tdata[(6+i)*WIDTH +: WIDTH];
        end
    end

    // Stage one: first-pass products, A and B carried for add, sub and negate.
    t_op   r_s1_op;
    t_comp r_s1_a [3];
    t_comp r_s1_b [3];
    t_comp r_s1_c [3];
    t_prod r_s1_pd [3];
    t_prod r_s1_px [3];
    t_prod r_s1_py [3];

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_op <= t_op'(i_s_tuser);
            for (int i = 0; i < 3; i++) begin
                r_s1_a[i]  <= in_a[i];
                r_s1_b[i]  <= in_b[i];
                r_s1_c[i]  <= in_c[i];
                r_s1_pd[i] <= PROD_W'(in_a[i]) * PROD_W'(in_b[i]);
                r_s1_px[i] <= PROD_W'(in_a[NXT1[i]]) * PROD_W'(in_b[NXT2[i]]);
                r_s1_py[i] <= PROD_W'(in_a[NXT2[i]]) * PROD_W'(in_b[NXT1[i]]);
            end
        end
    end

    // Stage two: first-pass sums, truncation and clamping.
    t_comp  n_s2_v [3];
    t_comp  n_s2_s;
    logic   n_s2_flag;

    always_comb begin
        t_wide  w_sel;
        t_wide  w_dot;
        t_clamp cl;
        n_s2_flag = 1'b0;
        for (int i = 0; i < 3; i++) begin
            case (r_s1_op) inside
                OP_ADD:  w_sel = SUM_W'(r_s1_a[i]) + SUM_W'(r_s1_b[i]);
                OP_SUB:  w_sel = SUM_W'(r_s1_a[i]) - SUM_W'(r_s1_b[i]);
                OP_NEG:  w_sel = -SUM_W'(r_s1_a[i]);
                OP_CMUL: w_sel = SUM_W'(r_s1_pd[i]) >>> FRAC_BITS;
                OP_DOT:  w_sel = '0;
                OP_CROSS, OP_STRIPLE, OP_VTRIPLE:
                    w_sel = (SUM_W'(r_s1_px[i]) - SUM_W'(r_s1_py[i])) >>> FRAC_BITS;
                default: w_sel = '0;
            endcase
            cl        = sat_clamp(w_sel);
            n_s2_v[i] = cl.val;
            n_s2_flag = n_s2_flag | cl.sat;
        end
        w_dot = (SUM_W'(r_s1_pd[0]) + SUM_W'(r_s1_pd[1]) + SUM_W'(r_s1_pd[2]))
                >>> FRAC_BITS;
        cl = sat_clamp(w_dot);
        if (r_s1_op == OP_DOT) begin
            n_s2_s    = cl.val;
            n_s2_flag = n_s2_flag | cl.sat;
        end else begin
            n_s2_s = '0;
        end
    end

    t_op   r_s2_op;
    t_comp r_s2_v [3];
    t_comp r_s2_c [3];
    t_comp r_s2_s;
    logic  r_s2_flag;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_s2_op   <= r_s1_op;
            r_s2_s    <= n_s2_s;
            r_s2_flag <= n_s2_flag;
            for (int i = 0; i < 3; i++) begin
                r_s2_v[i] <= n_s2_v[i];
                r_s2_c[i] <= r_s1_c[i];
            end
        end
    end

    // Stage three: second-pass products of the clamped cross product with C.
    t_op   r_s3_op;
    t_comp r_s3_v [3];
    t_comp r_s3_s;
    logic  r_s3_flag;
    t_prod r_s3_pd [3];
    t_prod r_s3_px [3];
    t_prod r_s3_py [3];

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_s3_op   <= r_s2_op;
            r_s3_s    <= r_s2_s;
            r_s3_flag <= r_s2_flag;
            for (int i = 0; i < 3; i++) begin
                r_s3_v[i]  <= r_s2_v[i];
                r_s3_pd[i] <= PROD_W'(r_s2_v[i]) * PROD_W'(r_s2_c[i]);
                r_s3_px[i] <= PROD_W'(r_s2_v[NXT1[i]]) * PROD_W'(r_s2_c[NXT2[i]]);
                r_s3_py[i] <= PROD_W'(r_s2_v[NXT2[i]]) * PROD_W'(r_s2_c[NXT1[i]]);
            end
        end
    end

    // Stage four: second-pass sums, clamping and result selection.
    t_comp n_res_v [3];
    t_comp n_res_s;
    logic  n_res_flag;

    always_comb begin
        t_clamp cl_x [3];
        t_clamp cl_d;
        logic   sat_x;
        sat_x = 1'b0;
        for (int i = 0; i < 3; i++) begin
            cl_x[i] = sat_clamp((SUM_W'(r_s3_px[i]) - SUM_W'(r_s3_py[i])) >>> FRAC_BITS);
            sat_x   = sat_x | cl_x[i].sat;
        end
        cl_d = sat_clamp((SUM_W'(r_s3_pd[0]) + SUM_W'(r_s3_pd[1]) + SUM_W'(r_s3_pd[2]))
                         >>> FRAC_BITS);
        case (r_s3_op) inside
            OP_STRIPLE: begin
                for (int i = 0; i < 3; i++) n_res_v[i] = '0;
                n_res_s    = cl_d.val;
                n_res_flag = r_s3_flag | cl_d.sat;
            end
            OP_VTRIPLE: begin
                for (int i = 0; i < 3; i++) n_res_v[i] = cl_x[i].val;
                n_res_s    = '0;
                n_res_flag = r_s3_flag | sat_x;
            end
            default: begin
                for (int i = 0; i < 3; i++) n_res_v[i] = r_s3_v[i];
                n_res_s    = r_s3_s;
                n_res_flag = r_s3_flag;
            end
        endcase
    end

    // Output register.
    t_comp r_res_v [3];
    t_comp r_res_s;
    logic  r_res_flag;

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_res_s    <= n_res_s;
            r_res_flag <= n_res_flag;
            for (int i = 0; i < 3; i++) r_res_v[i] <= n_res_v[i];
        end
    end

    assign o_m_tvalid   = r_v4;
    assign o_m_tdata    = M_TDATA_W'({r_res_s, r_res_v[2], r_res_v[1], r_res_v[0]});
    assign o_m_tuser[0] = r_res_flag;

endmodule

`default_nettype wire

FILE: rtl/vfa_checker.sv
// Port-level checker for the vec3 fixed-point vector unit, bound to the top level.
// Depends on vfa_pkg and vec3_fixed_point_alu_assert.svh.
`default_nettype none
`include "vec3_fixed_point_alu_assert.svh"

module vfa_checker
    import vfa_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_s_tready,
    input wire logic                 o_m_tvalid,
    input wire logic                 i_m_tready,
    input wire logic [M_TDATA_W-1:0] o_m_tdata,
    input wire logic [0:0]           o_m_tuser
);

    // Views of the result channel used by the properties below.
    logic                   w_stalled;
    logic [M_TDATA_W:0]     w_payload;
    logic [WIDTH-1:0]       w_scalar;
    logic [3*WIDTH-1:0]     w_vector;

    assign w_stalled = o_m_tvalid && !i_m_tready;
    assign w_payload = {o_m_tdata, o_m_tuser};
    assign w_scalar  = o_m_tdata[4*WIDTH-1:3*WIDTH];
    assign w_vector  = o_m_tdata[3*WIDTH-1:0];

    // A stalled result holds its valid and payload.
    `VFA_ASSERT(a_out_hold, i_clk, i_rst_n, w_stalled |=> o_m_tvalid && $stable(w_payload))

    // Reset empties the pipeline.
    `VFA_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_m_tvalid)

    // With no result waiting, nothing can block the request side.
    `VFA_ASSERT(a_ready_when_empty, i_clk, i_rst_n, !o_m_tvalid |-> o_s_tready)

    // A result is either a vector or a scalar, never both.
    `VFA_ASSERT(a_vec_or_scalar, i_clk, i_rst_n, o_m_tvalid |-> w_scalar == '0 || w_vector == '0)

endmodule

bind vec3_fixed_point_alu vfa_checker u_vfa_checker (.*);

`default_nettype wire

FILE: sim/vec3_fixed_point_alu_tb.sv
// Self-checking testbench for vec3_fixed_point_alu: a short table of directed requests
// followed by random requests with random stalls on both stream channels.
// Depends on vfa_pkg and the vec3_fixed_point_alu RTL.

module vec3_fixed_point_alu_tb;
    import vfa_pkg::*;

    localparam int NUM_DIRECTED  = 24;
    localparam int RANDOM_ITEMS  = 1526;
    localparam int MAX_WAIT      = 16;
    localparam int DRAIN_CYCLES  = 32;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int MAX_REPORTS   = 10;

    // Handy Q16.16 values.
    localparam t_comp C_MAX   = 32'sh7FFF_FFFF;
    localparam t_comp C_MIN   = 32'sh8000_0000;
    localparam t_comp C_ZERO  = 32'sh0000_0000;
    localparam t_comp C_ONE   = 32'sh0001_0000;
    localparam t_comp C_NEG1  = -32'sd1;
    localparam t_comp C_NOISE = 32'shDEAD_BEEF;

    // Limits of the result range at the width of the exact arithmetic.
    localparam logic signed [127:0] HI_LIM = {97'd0, {31{1'b1}}};
    localparam logic signed [127:0] LO_LIM = {{97{1'b1}}, 31'd0};

    typedef logic [0:2][WIDTH-1:0] t_vec3;

    typedef struct packed {
        t_comp x;
        t_comp y;
        t_comp z;
        t_comp s;
        logic  sat;
    } t_result;

    // One directed request; res holds x, y, z, scalar and is used only when chk is set.
    typedef struct packed {
        t_op                   op;
        t_vec3                 a;
        t_vec3                 b;
        t_vec3                 c;
        logic                  chk;
        logic [0:3][WIDTH-1:0] res;
        logic                  sat;
    } t_dir_row;

    typedef enum int {
        IDLE_BOTH,
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER
    } t_idle_mode;

    localparam t_dir_row DIRECTED [NUM_DIRECTED] = '{
        // Sums that run past both bounds.
        '{OP_ADD, {C_MAX, C_MIN, C_ONE}, {32'sd1, C_NEG1, 32'sh0002_0000},
          {C_NOISE, C_NOISE, C_NOISE},
          1'b1, {C_MAX, C_MIN, 32'sh0003_0000, C_ZERO}, 1'b1},
        '{OP_ADD, {C_ZERO, C_ZERO, C_ZERO}, {C_ZERO, C_ZERO, C_ZERO},
          {C_ZERO, C_ZERO, C_ZERO},
          1'b1, {C_ZERO, C_ZERO, C_ZERO, C_ZERO}, 1'b0},
        '{OP_SUB, {C_MIN, C_MAX, C_ZERO}, {32'sd1, C_NEG1, C_ZERO},
          {C_NOISE, C_NOISE, C_NOISE},
          1'b1, {C_MIN, C_MAX, C_ZERO, C_ZERO}, 1'b1},
        '{OP_SUB, {32'sh0003_0000, C_ZERO, -C_ONE}, {C_ONE, C_ONE, C_ONE},
          {C_ZERO, C_ZERO, C_ZERO},
          1'b1, {32'sh0002_0000, -C_ONE, 32'shFFFE_0000, C_ZERO}, 1'b0},
        // Negating the most negative value clamps to the maximum.
        '{OP_NEG, {C_MIN, C_MAX, C_ZERO}, {C_NOISE, C_NOISE, C_NOISE},
          {C_NOISE, C_NOISE, C_NOISE},
          1'b1, {C_MAX, 32'sh8000_0001, C_ZERO, C_ZERO}, 1'b1},
        '{OP_NEG, {C_ONE, -C_ONE, 32'sd5}, {C_NEG1, C_NEG1, C_NEG1},
          {C_NEG1, C_NEG1, C_NEG1},
          1'b1, {-C_ONE, C_ONE, -32'sd5, C_ZERO}, 1'b0},
        // Products truncate toward minus infinity.
        '{OP_CMUL, {32'sh0002_0000, C_NEG1, 32'sd1}, {32'sh0003_0000, 32'sd1, 32'sd1},
          {C_NOISE, C_NOISE, C_NOISE},
          1'b1, {32'sh0006_0000, C_NEG1, C_ZERO, C_ZERO}, 1'b0},
        '{OP_CMUL, {C_MAX, C_MIN, C_MIN}, {C_MAX, C_MIN, C_MAX},
          {C_ZERO, C_ZERO, C_ZERO},
          1'b1, {C_MAX, C_MAX, C_MIN, C_ZERO}, 1'b1},
        '{OP_DOT, {C_ONE, 32'sh0002_0000, 32'sh0003_0000},
          {32'sh0004_0000, 32'sh0005_0000, 32'sh0006_0000},
          {C_NOISE, C_NOISE, C_NOISE},
          1'b1, {C_ZERO, C_ZERO, C_ZERO, 32'sh0020_0000}, 1'b0},
        '{OP_DOT, {C_MIN, C_MIN, C_MIN}, {C_MIN, C_MIN, C_MIN},
          {C_ZERO, C_ZERO, C_ZERO},
          1'b1, {C_ZERO, C_ZERO, C_ZERO, C_MAX}, 1'b1},
        '{OP_DOT, {C_MIN, C_MIN, C_MIN}, {C_MAX, C_MAX, C_MAX},
          {C_ZERO, C_ZERO, C_ZERO},
          1'b1, {C_ZERO, C_ZERO, C_ZERO, C_MIN}, 1'b1},
        // The dot product sums exactly before the fraction is dropped.
        '{OP_DOT, {32'sd1, 32'sd1, C_ZERO}, {32'sh0000_8000, 32'sh0000_8000, C_ZERO},
          {C_ZERO, C_ZERO, C_ZERO},
          1'b1, {C_ZERO, C_ZERO, C_ZERO, 32'sd1}, 1'b0},
        '{OP_CROSS, {C_ONE, C_ZERO, C_ZERO}, {C_ZERO, C_ONE, C_ZERO},
          {C_NOISE, C_NOISE, C_NOISE},
          1'b1, {C_ZERO, C_ZERO, C_ONE, C_ZERO}, 1'b0},
        '{OP_CROSS, {32'sd1, C_ZERO, C_ZERO}, {C_ZERO, C_NEG1, C_ZERO},
          {C_ZERO, C_ZERO, C_ZERO},
          1'b1, {C_ZERO, C_ZERO, C_NEG1, C_ZERO}, 1'b0},
        '{OP_CROSS, {C_MAX, C_MIN, C_MAX}, {C_MIN, C_MAX, C_MIN},
          {C_ZERO, C_ZERO, C_ZERO},
          1'b0, '0, 1'b0},
        '{OP_STRIPLE, {C_ONE, C_ZERO, C_ZERO}, {C_ZERO, C_ONE, C_ZERO},
          {C_ZERO, C_ZERO, C_ONE},
          1'b1, {C_ZERO, C_ZERO, C_ZERO, C_ONE}, 1'b0},
        // Intermediate cross product clamps, final value stays in range.
        '{OP_STRIPLE, {C_ZERO, C_MAX, C_ZERO}, {C_ZERO, C_ZERO, C_MAX},
          {32'sd1, C_ZERO, C_ZERO},
          1'b1, {C_ZERO, C_ZERO, C_ZERO, 32'sh0000_7FFF}, 1'b1},
        '{OP_STRIPLE, {C_MIN, C_MIN, C_MIN}, {C_MAX, C_MIN, C_MAX},
          {C_MIN, C_MAX, C_MIN},
          1'b0, '0, 1'b0},
        '{OP_VTRIPLE, {C_ONE, C_ZERO, C_ZERO}, {C_ZERO, C_ONE, C_ZERO},
          {C_ONE, C_ZERO, C_ZERO},
          1'b1, {C_ZERO, C_ONE, C_ZERO, C_ZERO}, 1'b0},
        '{OP_VTRIPLE, {C_ZERO, C_MAX, C_ZERO}, {C_ZERO, C_ZERO, C_MAX},
          {C_ZERO, 32'sd1, C_ZERO},
          1'b1, {C_ZERO, C_ZERO, 32'sh0000_7FFF, C_ZERO}, 1'b1},
        '{OP_VTRIPLE, {C_MIN, C_MAX, C_MIN}, {C_MAX, C_MIN, C_MAX},
          {C_MIN, C_MIN, C_MAX},
          1'b0, '0, 1'b0},
        '{OP_SUB, {C_MIN, C_MAX, C_NEG1}, {C_MAX, C_MIN, C_MAX},
          {C_NOISE, C_NOISE, C_NOISE},
          1'b0, '0, 1'b0},
        '{OP_CMUL, {32'shFFFE_8000, C_MAX, 32'sd1}, {32'sh0001_8000, C_NEG1, C_MIN},
          {C_ZERO, C_ZERO, C_ZERO},
          1'b0, '0, 1'b0},
        '{OP_ADD, {C_NEG1, C_NEG1, C_NEG1}, {C_NEG1, C_NEG1, C_NEG1},
          {C_NEG1, C_NEG1, C_NEG1},
          1'b0, '0, 1'b0}
    };

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata;
    logic [OP_W-1:0]      i_s_tuser;
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic [0:0]           o_m_tuser;

    t_result     pending_results [$];
    t_idle_mode  idle_mode;
    int          tx_gap;
    logic        typed_valid;
    t_result     typed_result;
    int          cycle_count;
    int          mismatch_count;
    int          accepted_count;
    int          result_count;
    int          sat_count;
    int          op_seen [8];

    vec3_fixed_point_alu u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // Clock, period 8.
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Sign-extend a component to the width of the exact arithmetic.
    function automatic logic signed [127:0] widen(input t_comp v);
        return v;
    endfunction

    // Clamp an exact value to the component range, raising the flag when clamped.
    function automatic t_comp clip(input logic signed [127:0] v, inout logic sat);
        if (v > HI_LIM) begin
            sat = 1'b1;
            return C_MAX;
        end
        if (v < LO_LIM) begin
            sat = 1'b1;
            return C_MIN;
        end
        return t_comp'(v[WIDTH-1:0]);
    endfunction

    function automatic t_comp dot3(input t_vec3 p, input t_vec3 q, inout logic sat);
        logic signed [127:0] acc;
        acc = widen(p[0]) * widen(q[0]) + widen(p[1]) * widen(q[1])
            + widen(p[2]) * widen(q[2]);
        return clip(acc >>> FRAC_BITS, sat);
    endfunction

    function automatic void cross3(input t_vec3 p, input t_vec3 q, inout logic sat,
                                   output t_vec3 r);
        int j;
        int k;
        for (int i = 0; i < 3; i++) begin
            j = (i + 1) % 3;
            k = (i + 2) % 3;
            r[i] = clip((widen(p[j]) * widen(q[k]) - widen(p[k]) * widen(q[j]))
                        >>> FRAC_BITS, sat);
        end
    endfunction

    // Expected result of one request.
    function automatic t_result compute_vec3_result(input t_op op, input t_vec3 a,
                                                    input t_vec3 b, input t_vec3 c);
        t_result     r;
        t_vec3       v;
        t_vec3       d;
        t_comp       s;
        logic        sat;
        v   = '0;
        d   = '0;
        s   = C_ZERO;
        sat = 1'b0;
        case (op)
            OP_ADD: begin
                for (int i = 0; i < 3; i++) v[i] = clip(widen(a[i]) + widen(b[i]), sat);
            end
            OP_SUB: begin
                for (int i = 0; i < 3; i++) v[i] = clip(widen(a[i]) - widen(b[i]), sat);
            end
            OP_NEG: begin
                for (int i = 0; i < 3; i++) v[i] = clip(-widen(a[i]), sat);
            end
            OP_CMUL: begin
                for (int i = 0; i < 3; i++)
                    v[i] = clip((widen(a[i]) * widen(b[i])) >>> FRAC_BITS, sat);
            end
            OP_DOT: begin
                s = dot3(a, b, sat);
            end
            OP_CROSS: begin
                cross3(a, b, sat, v);
            end
            OP_STRIPLE: begin
                cross3(a, b, sat, d);
                s = dot3(d, c, sat);
            end
            OP_VTRIPLE: begin
                cross3(a, b, sat, d);
                cross3(d, c, sat, v);
            end
            default: begin
            end
        endcase
        r.x   = v[0];
        r.y   = v[1];
        r.z   = v[2];
        r.s   = s;
        r.sat = sat;
        return r;
    endfunction

    // Mostly log-spread magnitudes, with the notable values now and then.
    function automatic t_comp random_comp();
        t_comp v;
        if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 6))
                0: v = C_MAX;
                1: v = C_MIN;
                2: v = C_ZERO;
                3: v = 32'sd1;
                4: v = C_NEG1;
                5: v = C_ONE;
                default: v = -C_ONE;
            endcase
            return v;
        end
        v = $urandom;
        return v >>> $urandom_range(0, WIDTH - 1);
    endfunction

    function automatic t_vec3 random_vec();
        t_vec3 v;
        for (int i = 0; i < 3; i++) v[i] = random_comp();
        return v;
    endfunction

    // Idle cycles before the next request or result, by the current idling mode.
    function automatic int draw_wait(input bit receiver);
        case (idle_mode)
            IDLE_NONE:     return 0;
            IDLE_SENDER:   return receiver ? 0 : $urandom_range(0, MAX_WAIT);
            IDLE_RECEIVER: return receiver ? $urandom_range(0, MAX_WAIT) : 0;
            default:       return $urandom_range(0, MAX_WAIT);
        endcase
    endfunction

    // Present one request and hold it until accepted. Valid stays high only
    // when the next request follows without a gap.
    task automatic send_request(input t_op op, input t_vec3 a, input t_vec3 b,
                                input t_vec3 c, input logic typed,
                                input t_result typed_res);
        if (tx_gap > 0) begin
            i_s_tvalid = 1'b0;
            repeat (tx_gap) @(negedge i_clk);
        end
        i_s_tdata    = {c[2], c[1], c[0], b[2], b[1], b[0], a[2], a[1], a[0]};
        i_s_tuser    = op;
        typed_valid  = typed;
        typed_result = typed_res;
        i_s_tvalid   = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
        tx_gap = draw_wait(1'b0);
        if (tx_gap > 0) i_s_tvalid = 1'b0;
    endtask

    // Hold off new requests until every outstanding result has come back.
    task automatic wait_until_drained();
        i_s_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
    endtask

    // Receiver: random stalls on the result channel.
    initial begin : result_sink
        int stall;
        i_m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = draw_wait(1'b1);
            if (stall > 0) begin
                i_m_tready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            i_m_tready = 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            @(negedge i_clk);
        end
    end

    // Scoreboard: predict on every accepted request, compare every accepted result.
    always @(posedge i_clk) begin : scoreboard
        t_vec3       a;
        t_vec3       b;
        t_vec3       c;
        t_op         op;
        t_result     want;
        t_result     got;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                op = t_op'(i_s_tuser);
                for (int i = 0; i < 3; i++) begin
                    a[i] = i_s_tdata[i * WIDTH +: WIDTH];
                    b[i] = i_s_tdata[(3 + i) * WIDTH +: WIDTH];
                    c[i] = i_s_tdata[(6 + i) * WIDTH +: WIDTH];
                end
                want = typed_valid ? typed_result : compute_vec3_result(op, a, b, c);
                pending_results.push_back(want);
                accepted_count++;
                op_seen[op]++;
            end
            if (o_m_tvalid && i_m_tready) begin
                got.x   = o_m_tdata[0 * WIDTH +: WIDTH];
                got.y   = o_m_tdata[1 * WIDTH +: WIDTH];
                got.z   = o_m_tdata[2 * WIDTH +: WIDTH];
                got.s   = o_m_tdata[3 * WIDTH +: WIDTH];
                got.sat = o_m_tuser[0];
                result_count++;
                if (got.sat) sat_count++;
                if (pending_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("Result %0d arrived with no request outstanding: %h %h %h %h %b",
                                 result_count, got.x, got.y, got.z, got.s, got.sat);
                end else begin
                    want = pending_results.pop_front();
                    if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
                        got.s !== want.s || got.sat !== want.sat) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("Result %0d mismatch: expected x=%h y=%h z=%h s=%h sat=%b",
                                     result_count, want.x, want.y, want.z, want.s, want.sat);
                            $display("    got x=%h y=%h z=%h s=%h sat=%b",
                                     got.x, got.y, got.z, got.s, got.sat);
                        end
                    end
                end
            end
        end
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // Stimulus: reset, directed table, then random requests in idling phases.
    initial begin : stimulus
        t_dir_row row;
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_s_tuser      = OP_ADD;
        typed_valid    = 1'b0;
        typed_result   = '0;
        idle_mode      = IDLE_BOTH;
        tx_gap         = 0;
        cycle_count    = 0;
        mismatch_count = 0;
        accepted_count = 0;
        result_count   = 0;
        sat_count      = 0;
        foreach (op_seen[i]) op_seen[i] = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int n = 0; n < NUM_DIRECTED; n++) begin
            row = DIRECTED[n];
            send_request(row.op, row.a, row.b, row.c, row.chk,
                         t_result'({row.res, row.sat}));
        end
        wait_until_drained();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Each phase of 100 requests picks its own idling; the first runs flat out.
            if (n % 100 == 0)
                idle_mode = (n == 0) ? IDLE_NONE : t_idle_mode'($urandom_range(0, 3));
            if (n == RANDOM_ITEMS / 2) wait_until_drained();
            send_request(t_op'($urandom_range(0, 7)), random_vec(), random_vec(),
                         random_vec(), 1'b0, '0);
        end

        wait_until_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0d results never arrived.", pending_results.size());
            mismatch_count += pending_results.size();
        end

        $display("Covered %0d requests (%0d directed) and %0d results, %0d of them saturated.",
                 accepted_count, NUM_DIRECTED, result_count, sat_count);
        $display("Per operation, add through vector triple: %0d %0d %0d %0d %0d %0d %0d %0d.",
                 op_seen[OP_ADD], op_seen[OP_SUB], op_seen[OP_NEG], op_seen[OP_CMUL],
                 op_seen[OP_DOT], op_seen[OP_CROSS], op_seen[OP_STRIPLE],
                 op_seen[OP_VTRIPLE]);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/vfa_pkg.sv
rtl/vec3_fixed_point_alu.sv
rtl/vfa_checker.sv
sim/vec3_fixed_point_alu_tb.sv
